// ===== hw/rtl/cpd_pkg.sv =====
// cpd_pkg: constants, types and status codes for the closest-pair distance block.
// No dependencies; used by closest_pair_distance and cpd_checker.
package cpd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int IN_W       = 16;
    localparam int SQ_W       = 33;
    localparam int FIX_W      = 25;
    localparam int STATUS_W   = 2;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RAD_W  = 2 * FIX_W;
    localparam int REM_W  = FIX_W + 3;
    localparam int STEP_W = $clog2(FIX_W);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK       = status_t'(0);
    localparam status_t STATUS_FEW      = status_t'(1);
    localparam status_t STATUS_OVERFLOW = status_t'(2);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } point_t;

endpackage

// ===== hw/rtl/closest_pair_distance.sv =====
// closest_pair_distance: loads points one per cycle, then searches all pairs with one
// shared multiplier and takes a digit-by-digit square root. Depends on cpd_pkg.
// Load: one point per cycle, busy stays low. After the last point (n stored):
// n < 2 gives the result in the next cycle; otherwise the search reads points through the
// single memory read port, squares dx and dy on the shared multiplier, then yields
// one root bit per cycle. Result is a one-cycle done strobe; async reset clears the set.
module closest_pair_distance
    import cpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  coord_x,
    input  logic [IN_W-1:0]  coord_y,
    input  logic             last_point,
    output logic             done,
    output logic [SQ_W-1:0]  min_squared_distance,
    output logic [FIX_W-1:0] min_distance_fixed,
    output status_t          status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_I,
        S_LATCH_I,
        S_READ_J,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_CMP,
        S_SQRT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 overflow_reg;
    logic                 done_reg;
    logic [SQ_W-1:0]      sq_out_reg;
    logic [FIX_W-1:0]     fix_out_reg;
    status_t              status_reg;

    point_t               store_mem [MAX_POINTS];
    point_t               rd_data_reg;
    point_t               pi_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [SUM_W-1:0]     best_reg;
    logic [SUM_W-1:0]     best_next;
    logic [RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [FIX_W-1:0]     root_reg;
    logic [STEP_W-1:0]    step_reg;

    logic                 accept;
    logic                 room;
    logic                 wr_en;
    logic [CNT_W-1:0]     count_next;
    logic [COORD_BITS-1:0] mul_op;
    logic [PROD_W-1:0]    product;
    logic [SUM_W-1:0]     pair_sum;
    logic                 pair_more;
    logic                 row_more;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     trial;
    logic                 take;
    logic [REM_W-1:0]     rem_step;
    logic [FIX_W-1:0]     root_step;

    assign busy                 = (state_reg != S_IDLE);
    assign done                 = done_reg;
    assign min_squared_distance = sq_out_reg;
    assign min_distance_fixed   = fix_out_reg;
    assign status               = status_reg;

    assign accept     = start & ~busy;
    assign room       = (count_reg < CNT_W'(MAX_POINTS));
    assign wr_en      = accept & room;
    assign count_next = count_reg + CNT_W'(room);

    assign rd_addr = (state_reg == S_FETCH_I) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];

    // point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= '{x: COORD_BITS'(coord_x),
                                                  y: COORD_BITS'(coord_y)};
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign dx = (pi_reg.x >= rd_data_reg.x) ? pi_reg.x - rd_data_reg.x
                                            : rd_data_reg.x - pi_reg.x;
    assign dy = (pi_reg.y >= rd_data_reg.y) ? pi_reg.y - rd_data_reg.y
                                            : rd_data_reg.y - pi_reg.y;

    // shared squaring unit
    assign mul_op  = (state_reg == S_SQX) ? dx_reg : dy_reg;
    assign product = PROD_W'(mul_op) * PROD_W'(mul_op);

    assign pair_sum  = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    assign best_next = (pair_sum < best_reg) ? pair_sum : best_reg;
    assign pair_more = (CNT_W'(j_reg + CNT_W'(1)) < count_reg);
    assign row_more  = (CNT_W'(i_reg + CNT_W'(2)) < count_reg);

    // one root bit per step
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign take      = (rem_shift >= trial);
    assign rem_step  = take ? rem_shift - trial : rem_shift;
    assign root_step = {root_reg[FIX_W-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            done_reg     <= 1'b0;
            sq_out_reg   <= '0;
            fix_out_reg  <= '0;
            status_reg   <= STATUS_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            count_reg <= count_next;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (last_point)
                        begin
                            if (count_next < CNT_W'(2))
                            begin
                                sq_out_reg   <= '0;
                                fix_out_reg  <= '0;
                                status_reg   <= STATUS_FEW;
                                done_reg     <= 1'b1;
                                count_reg    <= '0;
                                overflow_reg <= 1'b0;
                            end
                            else
                            begin
                                state_reg <= S_FETCH_I;
                            end
                        end
                    end
                end
                S_FETCH_I: state_reg <= S_LATCH_I;
                S_LATCH_I: state_reg <= S_READ_J;
                S_READ_J:  state_reg <= S_DIFF;
                S_DIFF:    state_reg <= S_SQX;
                S_SQX:     state_reg <= S_SQY;
                S_SQY:     state_reg <= S_CMP;
                S_CMP:
                begin
                    priority if (pair_more)
                    begin
                        state_reg <= S_READ_J;
                    end
                    else if (row_more)
                    begin
                        state_reg <= S_FETCH_I;
                    end
                    else
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (step_reg == '0)
                    begin
                        sq_out_reg   <= SQ_W'(best_reg);
                        fix_out_reg  <= root_step;
                        status_reg   <= overflow_reg ? STATUS_OVERFLOW : STATUS_OK;
                        done_reg     <= 1'b1;
                        count_reg    <= '0;
                        overflow_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                i_reg    <= '0;
                j_reg    <= CNT_W'(1);
                best_reg <= '1;
            end
            S_LATCH_I: pi_reg <= rd_data_reg;
            S_DIFF:
            begin
                dx_reg <= dx;
                dy_reg <= dy;
            end
            S_SQX: prod_reg <= product;
            S_SQY:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= product;
            end
            S_CMP:
            begin
                best_reg <= best_next;
                priority if (pair_more)
                begin
                    j_reg <= CNT_W'(j_reg + CNT_W'(1));
                end
                else if (row_more)
                begin
                    i_reg <= CNT_W'(i_reg + CNT_W'(2) - CNT_W'(1));
                    j_reg <= CNT_W'(i_reg + CNT_W'(2));
                end
                else
                begin
                    rad_reg  <= RAD_W'({SQ_W'(best_next), FRAC_BITS'(0)});
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= STEP_W'(FIX_W - 1);
                end
            end
            S_SQRT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_step;
                root_reg <= root_step;
                step_reg <= step_reg - STEP_W'(1);
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/cpd_checker.sv =====
// cpd_checker: port-level assertions for closest_pair_distance, bound to the top level.
// Depends on cpd_pkg.
module cpd_checker
    import cpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             last_point,
    input logic             done,
    input logic [SQ_W-1:0]  min_squared_distance,
    input logic [FIX_W-1:0] min_distance_fixed,
    input status_t          status
);

    logic [63:0] fix64;
    logic [63:0] rad64;

    assign fix64 = 64'(min_distance_fixed);
    assign rad64 = 64'(min_squared_distance) << FRAC_BITS;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while searching");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_point) |=> (busy || done))
        else $error("last point transfer did not start a search");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("search ended without a result");

    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FEW) |->
            (min_squared_distance == '0 && min_distance_fixed == '0))
        else $error("nonzero distance with fewer than two points");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fix64 * fix64 <= rad64 && (fix64 + 64'd1) * (fix64 + 64'd1) > rad64))
        else $error("fixed distance is not the floor square root");

endmodule

bind closest_pair_distance cpd_checker u_cpd_checker (.*);

// ===== dv/closest_pair_distance_tb.sv =====
// Self-checking testbench for closest_pair_distance: streams point sets, predicts each result
// with an exhaustive pair search and an exact integer square root. Depends on cpd_pkg and the RTL.
module closest_pair_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpd_pkg::*;

    localparam int SEARCH_CYCLES = 2 * (MAX_POINTS - 1) + 5 * MAX_POINTS * (MAX_POINTS - 1) / 2 + 26;
    localparam int STALL_LIMIT   = 4 * SEARCH_CYCLES + 1000;
    localparam int TAIL_CYCLES   = 64;
    localparam int RANDOM_ITEMS  = 400;

    typedef enum int {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_EDGES} spread_t;

    typedef struct {
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        logic            last;
        int unsigned     gap;
    } point_item_t;

    typedef struct {
        logic [SQ_W-1:0]  sq;
        logic [FIX_W-1:0] fix;
        status_t          st;
    } distance_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [IN_W-1:0]  coord_x = '0;
    logic [IN_W-1:0]  coord_y = '0;
    logic             last_point = 1'b0;
    logic             done;
    logic [SQ_W-1:0]  min_squared_distance;
    logic [FIX_W-1:0] min_distance_fixed;
    status_t          status;

    point_item_t     pending_points[$];
    distance_t       expected_distances[$];
    logic [IN_W-1:0] stored_x[MAX_POINTS];
    logic [IN_W-1:0] stored_y[MAX_POINTS];
    int              stored_count = 0;
    logic            dropped_point = 1'b0;

    int          issued_cnt = 0;
    int          accepted_cnt = 0;
    int unsigned gap_left = 0;
    int          stall_cycles = 0;
    int          results_seen = 0;
    int          err_count = 0;
    int          sets_queued = 0;
    int          items_queued = 0;

    closest_pair_distance dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .coord_x              (coord_x),
        .coord_y              (coord_y),
        .last_point           (last_point),
        .done                 (done),
        .min_squared_distance (min_squared_distance),
        .min_distance_fixed   (min_distance_fixed),
        .status               (status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [FIX_W-1:0] fixed_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = FIX_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r[FIX_W-1:0];
    endfunction

    // store one point; on the last one of a set, search all pairs and queue the result
    function automatic void track_point(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                                        input logic last);
        distance_t   res;
        logic [63:0] best;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] d;
        if (stored_count < MAX_POINTS)
        begin
            stored_x[stored_count] = x;
            stored_y[stored_count] = y;
            stored_count++;
        end
        else
            dropped_point = 1'b1;
        if (last)
        begin
            if (stored_count < 2)
            begin
                res.sq  = '0;
                res.fix = '0;
                res.st  = STATUS_FEW;
            end
            else
            begin
                best = '1;
                for (int i = 0; i < stored_count; i++)
                    for (int j = i + 1; j < stored_count; j++)
                    begin
                        dx = (stored_x[i] >= stored_x[j]) ? stored_x[i] - stored_x[j]
                                                          : stored_x[j] - stored_x[i];
                        dy = (stored_y[i] >= stored_y[j]) ? stored_y[i] - stored_y[j]
                                                          : stored_y[j] - stored_y[i];
                        d = dx * dx + dy * dy;
                        if (d < best)
                            best = d;
                    end
                res.sq  = best[SQ_W-1:0];
                res.fix = fixed_root({31'd0, res.sq} << FRAC_BITS);
                res.st  = dropped_point ? STATUS_OVERFLOW : STATUS_OK;
            end
            expected_distances.push_back(res);
            stored_count  = 0;
            dropped_point = 1'b0;
        end
    endfunction

    task automatic add_point(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                             input logic last, input int unsigned gap);
        point_item_t item;
        item.x    = x;
        item.y    = y;
        item.last = last;
        item.gap  = gap;
        pending_points.push_back(item);
        items_queued++;
        if (last)
            sets_queued++;
    endtask

    task automatic queue_set(input int n, input spread_t spread, input int unsigned gap_max);
        logic [IN_W-1:0] base_x;
        logic [IN_W-1:0] base_y;
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        base_x = IN_W'($urandom_range(0, 65531));
        base_y = IN_W'($urandom_range(0, 65531));
        for (int k = 0; k < n; k++)
        begin
            case (spread)
                SPREAD_CLUSTER:
                begin
                    x = base_x + IN_W'($urandom_range(0, 3));
                    y = base_y + IN_W'($urandom_range(0, 3));
                end
                SPREAD_EDGES:
                begin
                    x = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    y = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    if ($urandom_range(0, 3) == 0)
                        x = IN_W'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        y = IN_W'($urandom);
                end
                default:
                begin
                    x = IN_W'($urandom);
                    y = IN_W'($urandom);
                end
            endcase
            add_point(x, y, k == n - 1, $urandom_range(0, gap_max));
        end
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || issued_cnt != accepted_cnt ||
               expected_distances.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    // driver: present items at the falling edge, hold start until the transfer is seen
    always @(negedge clk)
    begin
        point_item_t item;
        if (rst_n)
        begin
            if (accepted_cnt == issued_cnt)
            begin
                if (gap_left != 0)
                begin
                    start      <= 1'b0;
                    gap_left   <= gap_left - 1;
                    coord_x    <= IN_W'($urandom);
                    coord_y    <= IN_W'($urandom);
                    last_point <= 1'($urandom);
                end
                else if (pending_points.size() != 0)
                begin
                    item = pending_points.pop_front();
                    start      <= 1'b1;
                    coord_x    <= item.x;
                    coord_y    <= item.y;
                    last_point <= item.last;
                    gap_left   <= item.gap;
                    issued_cnt <= issued_cnt + 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: record transfers, check each result strobe against the oldest prediction
    always @(posedge clk)
    begin
        distance_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                accepted_cnt <= accepted_cnt + 1;
                track_point(coord_x, coord_y, last_point);
            end
            if (done)
            begin
                results_seen++;
                if (expected_distances.size() == 0)
                begin
                    $error("result strobe with no result pending");
                    err_count++;
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (min_squared_distance !== want.sq)
                    begin
                        $error("min_squared_distance: expected %0d, got %0d",
                               want.sq, min_squared_distance);
                        err_count++;
                    end
                    if (min_distance_fixed !== want.fix)
                    begin
                        $error("min_distance_fixed: expected %0d, got %0d",
                               want.fix, min_distance_fixed);
                        err_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        err_count++;
                    end
                end
            end
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("closest_pair_distance_tb: errors");
        $finish;
    end

    initial
    begin
        int n;
        int pick;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // single points, coordinate extremes, coincident and unit-distance pairs
        add_point(16'd0, 16'd0, 1'b1, $urandom_range(0, 9));
        add_point(16'hffff, 16'hffff, 1'b1, $urandom_range(0, 9));
        add_point(16'd0, 16'd0, 1'b0, $urandom_range(0, 9));
        add_point(16'hffff, 16'hffff, 1'b1, $urandom_range(0, 9));
        add_point(16'hffff, 16'd0, 1'b0, $urandom_range(0, 9));
        add_point(16'd0, 16'hffff, 1'b1, $urandom_range(0, 9));
        add_point(16'd123, 16'd456, 1'b0, $urandom_range(0, 9));
        add_point(16'd9000, 16'd9000, 1'b0, $urandom_range(0, 9));
        add_point(16'd123, 16'd456, 1'b1, $urandom_range(0, 9));
        add_point(16'd100, 16'd100, 1'b0, $urandom_range(0, 9));
        add_point(16'd101, 16'd100, 1'b0, $urandom_range(0, 9));
        add_point(16'd40000, 16'd2, 1'b0, $urandom_range(0, 9));
        add_point(16'd100, 16'd101, 1'b1, $urandom_range(0, 9));
        add_point(16'd0, 16'hffff, 1'b0, $urandom_range(0, 9));
        add_point(16'd3, 16'd65531, 1'b1, $urandom_range(0, 9));
        add_point(16'd32768, 16'd32767, 1'b0, $urandom_range(0, 9));
        add_point(16'd32767, 16'd32768, 1'b0, $urandom_range(0, 9));
        add_point(16'd21845, 16'd43690, 1'b1, $urandom_range(0, 9));
        wait_drained();

        // random sets, mostly small
        while (items_queued < 18 + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                n = 1;
            else if (pick < 85)
                n = $urandom_range(2, 12);
            else if (pick < 97)
                n = $urandom_range(13, 32);
            else
                n = $urandom_range(33, 64);
            queue_set(n, spread_t'($urandom_range(0, 2)), ($urandom_range(0, 9) < 3) ? 0 : 9);
        end
        wait_drained();

        // one set past capacity, back to back
        queue_set(MAX_POINTS + 2, SPREAD_WIDE, 0);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d point transfers in %0d sets, %0d results checked", accepted_cnt,
                 sets_queued, results_seen);
        $display("covered single points, extremes, coincident points and a %0d-point overflow set",
                 MAX_POINTS + 2);
        if (err_count == 0)
            $display("closest_pair_distance_tb: clean");
        else
            $display("closest_pair_distance_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cpd_pkg.sv
hw/rtl/closest_pair_distance.sv
hw/rtl/cpd_checker.sv
dv/closest_pair_distance_tb.sv
